/* sv/thpg_pkg.sv */
// Shared types, constants and the control program of the toroidal hue plasma grid.
// Holds the payload structs, datapath select codes and the microcode ROM.
// No dependencies.
package thpg_pkg;

  localparam int DEF_GRID_WIDTH  = 32;
  localparam int DEF_GRID_HEIGHT = 32;

  localparam int HUE_BITS = 16;

  // Item codes
  localparam logic [1:0] FUNC_PAINT = 2'd0;
  localparam logic [1:0] FUNC_ZERO  = 2'd1;
  localparam logic [1:0] FUNC_SEED  = 2'd2;

  localparam logic [16:0] SPARK_LIMIT = 17'd99945;
  localparam logic [15:0] HUE_WRAP    = 16'd720;

  // floor(v / 720) == (v * RECIP_720) >> RECIP_SHIFT for every 16-bit v
  localparam int          RECIP_SHIFT = 26;
  localparam logic [16:0] RECIP_720   = 17'd93207;

  typedef struct packed {
    logic [1:0]  func;
    logic [16:0] spark_draw;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [15:0] seed_value;
  } cmd_t;

  typedef struct packed {
    logic [4:0] pixel_x;
    logic [4:0] pixel_y;
    logic [8:0] hue;
    logic       frame_end;
  } pixel_t;

  typedef enum logic [2:0] {
    ADDR_CENTER,
    ADDR_LEFT,
    ADDR_RIGHT,
    ADDR_ABOVE,
    ADDR_BELOW,
    ADDR_GIVEN,
    ADDR_CLEAR
  } addr_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SMOOTH,
    WR_ZERO,
    WR_GIVEN
  } wr_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CAPTURE,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_DISPATCH,
    JMP_NO_SPARK,
    JMP_CLEAR,
    JMP_OUT_FREE
  } jmp_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_RD_C  = 4'd1;
  localparam step_t STEP_RD_L  = 4'd2;
  localparam step_t STEP_RD_R  = 4'd3;
  localparam step_t STEP_RD_U  = 4'd4;
  localparam step_t STEP_RD_D  = 4'd5;
  localparam step_t STEP_ACC   = 4'd6;
  localparam step_t STEP_WR_C  = 4'd7;
  localparam step_t STEP_WR_R  = 4'd8;
  localparam step_t STEP_WR_D  = 4'd9;
  localparam step_t STEP_HUE_Q = 4'd10;
  localparam step_t STEP_EMIT  = 4'd11;
  localparam step_t STEP_WR_G  = 4'd12;
  localparam step_t STEP_CLEAR = 4'd13;

  typedef struct packed {
    addr_sel_t addr_sel;
    wr_sel_t   wr_sel;
    acc_op_t   acc_op;
    logic      hv_load;
    logic      mul_load;
    logic      emit;
    jmp_t      jmp;
    step_t     target;
  } ucode_t;

  // Control ROM: one word per step
  function automatic ucode_t ucode(input step_t step);
    ucode_t w;
    w = '{ADDR_CENTER, WR_NONE, ACC_HOLD, 1'b0, 1'b0, 1'b0, JMP_GOTO, STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.jmp = JMP_DISPATCH;
      end
      STEP_RD_C: begin
        w.addr_sel = ADDR_CENTER;
        w.jmp      = JMP_NEXT;
      end
      STEP_RD_L: begin
        w.addr_sel = ADDR_LEFT;
        w.acc_op   = ACC_CAPTURE;
        w.jmp      = JMP_NEXT;
      end
      STEP_RD_R: begin
        w.addr_sel = ADDR_RIGHT;
        w.acc_op   = ACC_LOAD;
        w.jmp      = JMP_NEXT;
      end
      STEP_RD_U: begin
        w.addr_sel = ADDR_ABOVE;
        w.acc_op   = ACC_ADD;
        w.jmp      = JMP_NEXT;
      end
      STEP_RD_D: begin
        w.addr_sel = ADDR_BELOW;
        w.acc_op   = ACC_ADD;
        w.jmp      = JMP_NEXT;
      end
      STEP_ACC: begin
        w.acc_op = ACC_ADD;
        w.jmp    = JMP_NEXT;
      end
      STEP_WR_C: begin
        w.addr_sel = ADDR_CENTER;
        w.wr_sel   = WR_SMOOTH;
        w.hv_load  = 1'b1;
        w.jmp      = JMP_NO_SPARK;
        w.target   = STEP_HUE_Q;
      end
      STEP_WR_R: begin
        w.addr_sel = ADDR_RIGHT;
        w.wr_sel   = WR_ZERO;
        w.jmp      = JMP_NEXT;
      end
      STEP_WR_D: begin
        w.addr_sel = ADDR_BELOW;
        w.wr_sel   = WR_ZERO;
        w.jmp      = JMP_NEXT;
      end
      STEP_HUE_Q: begin
        w.mul_load = 1'b1;
        w.jmp      = JMP_NEXT;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.jmp    = JMP_OUT_FREE;
        w.target = STEP_IDLE;
      end
      STEP_WR_G: begin
        w.addr_sel = ADDR_GIVEN;
        w.wr_sel   = WR_GIVEN;
        w.jmp      = JMP_GOTO;
        w.target   = STEP_IDLE;
      end
      STEP_CLEAR: begin
        w.addr_sel = ADDR_CLEAR;
        w.wr_sel   = WR_ZERO;
        w.jmp      = JMP_CLEAR;
        w.target   = STEP_IDLE;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/thpg_chan_if.sv */
// Valid/ready channel carrying one payload of type T.
// Used for the command, pixel and configuration channels; no dependencies.
interface thpg_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/toroidal_hue_plasma_grid.sv */
// Toroidal hue plasma grid: microcoded sequencer around one grid RAM.
// Depends on thpg_pkg, thpg_chan_if and thpg_ram.
//
// cmd:   one item per handshake. func 0 paints the next cell of the row-by-row
//        scan; func 1 zeroes and func 2 seeds the cell at (cell_x, cell_y).
//        Out-of-range cells and func 3 are dropped in the accept cycle.
// pixel: one result per paint item: coordinates, display hue (stored value
//        mod 720, halved) and frame_end on the last cell of the scan.
// cfg:   writes sound_reactive (reset 1); always ready.
// Sequence: a paint item reaches the pixel register after five reads and up to
//   three writes through the single grid RAM port plus the hue reduction step;
//   cmd is ready again once the result is in the pixel register, so a new item
//   is taken only after the previous one is done. Zero and seed items write
//   their cell and return to idle. cmd is ready only at the idle step.
// Reset: the sequencer sweeps all GRID_WIDTH*GRID_HEIGHT cells (1024 by default),
//   zeroing one cell per cycle, with cmd not ready.
//   Scan position returns to the top-left cell.
// Stall: the pixel register holds a finished result; a paint item runs up to
//   its emit step and waits there while the previous pixel is not taken.
module toroidal_hue_plasma_grid #(
  parameter int GRID_WIDTH  = thpg_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = thpg_pkg::DEF_GRID_HEIGHT
) (
  input logic         clk,
  input logic         rst,
  thpg_chan_if.sink   cmd,
  thpg_chan_if.source pixel,
  thpg_chan_if.sink   cfg
);

  import thpg_pkg::*;

  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_WIDTH);
  localparam int RW    = $clog2(GRID_HEIGHT);

  localparam logic [CW-1:0] LAST_COL  = CW'(GRID_WIDTH - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(GRID_HEIGHT - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Sequencer state
  step_t   pc;
  step_t   pc_next;
  ucode_t  uw;

  // Latched command
  logic [1:0]  func_r;
  logic [16:0] draw_r;
  logic [4:0]  cx_r;
  logic [4:0]  cy_r;
  logic [15:0] seed_r;

  // Datapath
  logic [15:0] c_r;
  logic [17:0] acc;
  logic [15:0] hv;
  logic [32:0] prod;
  logic [AW-1:0] clr_addr;
  logic          sound_reactive;

  logic [CW-1:0] scan_column;
  logic [RW-1:0] scan_row;

  // RAM port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_rdata;

  logic          spark;
  logic          changed;
  logic [20:0]   smooth_sum;
  logic [15:0]   hv_next;
  logic [6:0]    quot;
  logic [15:0]   rem;
  logic          out_free;
  logic          emit_fire;
  logic          cmd_fire;
  logic          given_ok;

  logic [CW-1:0] col_left;
  logic [CW-1:0] col_right;
  logic [RW-1:0] row_above;
  logic [RW-1:0] row_below;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x,
                                            input logic [RW-1:0] y);
    return AW'(AW'(y) * AW'(GRID_WIDTH)) + AW'(x);
  endfunction

  assign uw = ucode(pc);

  // Handshakes
  assign cmd.ready = (pc == STEP_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !pixel.valid || pixel.ready;
  assign emit_fire = uw.emit && out_free;

  assign given_ok = ({27'd0, cmd.payload.cell_x} < 32'(GRID_WIDTH))
                 && ({27'd0, cmd.payload.cell_y} < 32'(GRID_HEIGHT));

  // Wrapped neighbours of the scan cell
  assign col_left  = (scan_column == '0) ? LAST_COL : scan_column - 1'b1;
  assign col_right = (scan_column == LAST_COL) ? '0 : scan_column + 1'b1;
  assign row_above = (scan_row == '0) ? LAST_ROW : scan_row - 1'b1;
  assign row_below = (scan_row == LAST_ROW) ? '0 : scan_row + 1'b1;

  // Smoothing: ceil((12c + S + 24) / 16), kept to 16 bits, only when S != 4c; a spark gives 0
  assign spark      = !sound_reactive && (draw_r > SPARK_LIMIT);
  assign changed    = (acc != {c_r, 2'b00});
  assign smooth_sum = ({5'd0, c_r} << 3) + ({5'd0, c_r} << 2) + {3'd0, acc} + 21'd39;
  assign hv_next    = spark ? 16'd0 : (changed ? smooth_sum[19:4] : c_r);

  // Hue reduction: v - 720 * floor(v / 720)
  assign quot = prod[32:26];
  assign rem  = hv - 16'(16'(quot) * HUE_WRAP);

  // Address select
  always_comb begin
    case (uw.addr_sel)
      ADDR_CENTER: mem_addr = addr_of(scan_column, scan_row);
      ADDR_LEFT:   mem_addr = addr_of(col_left, scan_row);
      ADDR_RIGHT:  mem_addr = addr_of(col_right, scan_row);
      ADDR_ABOVE:  mem_addr = addr_of(scan_column, row_above);
      ADDR_BELOW:  mem_addr = addr_of(scan_column, row_below);
      ADDR_GIVEN:  mem_addr = addr_of(CW'(cx_r), RW'(cy_r));
      ADDR_CLEAR:  mem_addr = clr_addr;
      default:     mem_addr = clr_addr;
    endcase
  end

  // Write select: the center write only lands when the cell changes or a spark fires
  always_comb begin
    case (uw.wr_sel)
      WR_SMOOTH: begin
        mem_we    = spark || changed;
        mem_wdata = hv_next;
      end
      WR_ZERO: begin
        mem_we    = 1'b1;
        mem_wdata = 16'd0;
      end
      WR_GIVEN: begin
        mem_we    = 1'b1;
        mem_wdata = (func_r == FUNC_SEED) ? seed_r : 16'd0;
      end
      default: begin
        mem_we    = 1'b0;
        mem_wdata = 16'd0;
      end
    endcase
  end

  // Step counter with conditional jumps
  always_comb begin
    case (uw.jmp)
      JMP_NEXT: pc_next = pc + 1'b1;
      JMP_GOTO: pc_next = uw.target;
      JMP_DISPATCH: begin
        pc_next = STEP_IDLE;
        if (cmd.valid) begin
          if (cmd.payload.func == FUNC_PAINT) begin
            pc_next = STEP_RD_C;
          end else if ((cmd.payload.func == FUNC_ZERO || cmd.payload.func == FUNC_SEED)
                       && given_ok) begin
            pc_next = STEP_WR_G;
          end
        end
      end
      JMP_NO_SPARK: pc_next = spark ? pc + 1'b1 : uw.target;
      JMP_CLEAR:    pc_next = (clr_addr == LAST_ADDR) ? uw.target : pc;
      JMP_OUT_FREE: pc_next = out_free ? uw.target : pc;
      default:      pc_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_CLEAR;
    end else begin
      pc <= pc_next;
    end
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (uw.addr_sel == ADDR_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      sound_reactive <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      sound_reactive <= cfg.payload;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      func_r <= cmd.payload.func;
      draw_r <= cmd.payload.spark_draw;
      cx_r   <= cmd.payload.cell_x;
      cy_r   <= cmd.payload.cell_y;
      seed_r <= cmd.payload.seed_value;
    end
  end

  // Neighbour accumulation and hue pipeline
  always_ff @(posedge clk) begin
    case (uw.acc_op)
      ACC_CAPTURE: c_r <= mem_rdata;
      ACC_LOAD:    acc <= {2'd0, mem_rdata};
      ACC_ADD:     acc <= acc + {2'd0, mem_rdata};
      default:     acc <= acc;
    endcase
    if (uw.hv_load) begin
      hv <= hv_next;
    end
    if (uw.mul_load) begin
      prod <= {17'd0, hv} * {16'd0, RECIP_720};
    end
  end

  // Scan position: advance as each pixel enters the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column <= '0;
      scan_row    <= '0;
    end else if (emit_fire) begin
      if (scan_column == LAST_COL) begin
        scan_column <= '0;
        scan_row    <= (scan_row == LAST_ROW) ? '0 : scan_row + 1'b1;
      end else begin
        scan_column <= scan_column + 1'b1;
      end
    end
  end

  // Pixel output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (emit_fire) begin
      pixel.valid <= 1'b1;
    end else if (pixel.ready) begin
      pixel.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      pixel.payload.pixel_x   <= 5'(scan_column);
      pixel.payload.pixel_y   <= 5'(scan_row);
      pixel.payload.hue       <= rem[9:1];
      pixel.payload.frame_end <= (scan_column == LAST_COL) && (scan_row == LAST_ROW);
    end
  end

  thpg_ram #(
    .WIDTH (HUE_BITS),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

/* sv/thpg_ram.sv */
// Generic single-port RAM with registered read data.
// Width and depth come from parameters; no dependencies.
module thpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
